// ===== design/first_fit_heap_allocator_unit_macros.svh =====
// Assertion macros for the first-fit heap allocator.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define FFH_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FFH_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FFH_ASSERT(label, clk, rst_n, prop, msg)
`define FFH_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== design/ffha_pkg.sv =====
// Package with shared types and codes of the first-fit heap allocator.
`timescale 1ns / 1ps
package ffha_pkg;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_A_RD, S_A_CHK, S_A_SPLIT, S_A_LINK, S_A_FIX,
    S_F_RD, S_F_NEXT, S_F_NLINK, S_F_PREV, S_F_PLINK, S_F_FIX, S_DONE
  } state_t;
endpackage

// ===== design/ffha_table.sv =====
// Block table memory with one registered read port and one write port.
`timescale 1ns / 1ps
module ffha_table #(
  parameter int AW = 6,
  parameter int LW = 7
) (
  input  logic          clk,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_start,
  output logic          rd_used,
  output logic [LW-1:0] rd_len,
  output logic [AW-1:0] rd_prev,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_start,
  input  logic          wr_used,
  input  logic [LW-1:0] wr_len,
  input  logic [AW-1:0] wr_prev
);
  localparam int DW = 2 + LW + AW;
  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_start, wr_used, wr_len, wr_prev};
    end
    q_r <= mem[rd_addr];
  end

  assign {rd_start, rd_used, rd_len, rd_prev} = q_r;
endmodule

// ===== design/first_fit_heap_allocator_unit.sv =====
// Top level of the first-fit heap allocator with its sequencer.
//
// The block keeps a heap as address-ordered blocks in a table with one entry
// per granule. An item on the in_ channel (in_valid/in_ready) either allocates
// request bytes or frees a payload offset; each item gives exactly one item on
// the out_ channel (out_valid/out_ready) with a status and a payload offset.
// One item is worked at a time by a sequencer around the table's ports.
// An allocate walks the block list, reading and checking each visited block
// (up to 64), until a free block that fits is found or the list ends. A valid
// free reads its block, then the next and previous blocks to merge free ones.
// in_ready returns in the same cycle that the result enters the output register.
// After reset the table is swept, one entry per cycle, over every entry while
// in_ready stays low.
// The result waits in an output register; while the receiver stalls, the next
// item can still be worked, and its result then waits in the sequencer until
// the output register is free.
// Reset is synchronous and active low.
`timescale 1ns / 1ps
`include "first_fit_heap_allocator_unit_macros.svh"
module first_fit_heap_allocator_unit #(
  parameter int HEAP_BYTES = 512,
  parameter int GRANULE_BYTES = 8,
  parameter int HEADER_GRANULES = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_op,
  input  logic [9:0] in_request_bytes,
  input  logic [8:0] in_free_offset,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic [8:0] out_payload_offset
);
  import ffha_pkg::*;
  localparam int NG = HEAP_BYTES / GRANULE_BYTES;
  localparam int AW = (NG > 1) ? $clog2(NG) : 1;
  localparam int LW = $clog2(NG + 1);
  localparam int GW = LW + 2;
  localparam int GSH = $clog2(GRANULE_BYTES);

  state_t state_r, state_nxt;
  logic [GW-1:0] need_r, need_nxt;
  logic [GW-1:0] g_r, g_nxt;
  logic [GW-1:0] n_r, n_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [AW-1:0] prev_r, prev_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [8:0]    pay_r, pay_nxt;
  logic          merged_r, merged_nxt;
  logic          fused_r, fused_nxt;
  logic [LW-1:0] flen_r, flen_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [8:0]    out_pay_r, out_pay_nxt;

  logic          rd_start, rd_used;
  logic [LW-1:0] rd_len;
  logic [AW-1:0] rd_prev;
  logic [AW-1:0] rd_addr;
  logic          wr_en, wr_start, wr_used;
  logic [AW-1:0] wr_addr, wr_prev;
  logic [LW-1:0] wr_len;

  logic [GW-1:0] gran_w, off_g_w, sum_w;
  logic          accept_w, nmerge_w, pmerge_w, emit_w;

  ffha_table #(.AW(AW), .LW(LW)) u_table (
    .clk, .rd_addr, .rd_start, .rd_used, .rd_len, .rd_prev,
    .wr_en, .wr_addr, .wr_start, .wr_used, .wr_len, .wr_prev
  );

  assign accept_w = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign gran_w = GW'((in_request_bytes + 11'(GRANULE_BYTES - 1)) >> GSH);
  assign off_g_w = GW'(in_free_offset >> GSH);
  assign sum_w = g_r + GW'(len_r);
  assign nmerge_w = (n_r < GW'(NG)) && rd_start && !rd_used;
  assign pmerge_w = (g_r != '0) && rd_start && !rd_used;
  assign emit_w = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      out_valid_r <= 1'b0;
      clr_r <= '0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      clr_r <= clr_nxt;
    end
    need_r <= need_nxt;
    g_r <= g_nxt;
    n_r <= n_nxt;
    len_r <= len_nxt;
    prev_r <= prev_nxt;
    status_r <= status_nxt;
    pay_r <= pay_nxt;
    merged_r <= merged_nxt;
    fused_r <= fused_nxt;
    flen_r <= flen_nxt;
    out_status_r <= out_status_nxt;
    out_pay_r <= out_pay_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_r == AW'(NG - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept_w) begin
          if (in_op == OP_ALLOC) begin
            state_nxt = S_A_RD;
          end else if ((in_free_offset & 9'(GRANULE_BYTES - 1)) != 0 ||
                       off_g_w < GW'(HEADER_GRANULES) ||
                       off_g_w - GW'(HEADER_GRANULES) >= GW'(NG)) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_F_RD;
          end
        end
      end
      S_A_RD: state_nxt = S_A_CHK;
      S_A_CHK: begin
        if (rd_len == 0) state_nxt = S_DONE;
        else if (!rd_used && GW'(rd_len) >= need_r) state_nxt = S_A_SPLIT;
        else if (g_r + GW'(rd_len) >= GW'(NG)) state_nxt = S_DONE;
        else state_nxt = S_A_RD;
      end
      S_A_SPLIT: begin
        if (GW'(len_r) == need_r) state_nxt = S_DONE;
        else state_nxt = S_A_LINK;
      end
      S_A_LINK: begin
        if (sum_w < GW'(NG) && rd_start) state_nxt = S_A_FIX;
        else state_nxt = S_DONE;
      end
      S_A_FIX: state_nxt = S_DONE;
      S_F_RD: state_nxt = S_F_NEXT;
      S_F_NEXT: begin
        if (!rd_start || !rd_used) state_nxt = S_DONE;
        else state_nxt = S_F_NLINK;
      end
      S_F_NLINK: state_nxt = S_F_PREV;
      S_F_PREV: state_nxt = S_F_PLINK;
      S_F_PLINK: begin
        if (merged_r && sum_w < GW'(NG) && rd_start) state_nxt = S_F_FIX;
        else state_nxt = S_DONE;
      end
      S_F_FIX: state_nxt = S_DONE;
      S_DONE: if (emit_w) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    need_nxt = need_r;
    g_nxt = g_r;
    n_nxt = n_r;
    len_nxt = len_r;
    prev_nxt = prev_r;
    clr_nxt = clr_r;
    status_nxt = status_r;
    pay_nxt = pay_r;
    merged_nxt = merged_r;
    fused_nxt = fused_r;
    flen_nxt = flen_r;
    out_status_nxt = out_status_r;
    out_pay_nxt = out_pay_r;
    out_valid_nxt = out_valid_r;
    rd_addr = AW'(g_r);
    wr_en = 1'b0;
    wr_addr = AW'(g_r);
    wr_start = 1'b0;
    wr_used = 1'b0;
    wr_len = '0;
    wr_prev = '0;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        wr_en = 1'b1;
        wr_addr = clr_r;
        wr_start = (clr_r == '0);
        wr_len = (clr_r == '0) ? LW'(NG) : '0;
        clr_nxt = clr_r + 1'b1;
      end
      S_IDLE: begin
        if (accept_w) begin
          g_nxt = '0;
          pay_nxt = '0;
          merged_nxt = 1'b0;
          need_nxt = ((gran_w == 0) ? GW'(1) : gran_w) + GW'(HEADER_GRANULES);
          if (in_op == OP_ALLOC) begin
            status_nxt = ST_NOFIT;
          end else begin
            status_nxt = ST_BADFREE;
            g_nxt = off_g_w - GW'(HEADER_GRANULES);
          end
        end
      end
      S_A_RD: ;
      S_A_CHK: begin
        len_nxt = rd_len;
        prev_nxt = rd_prev;
        if (!(rd_len == 0) && !(!rd_used && GW'(rd_len) >= need_r)) begin
          g_nxt = g_r + GW'(rd_len);
        end
      end
      S_A_SPLIT: begin
        wr_en = 1'b1;
        wr_start = 1'b1;
        wr_used = 1'b1;
        wr_len = LW'(need_r);
        wr_prev = prev_r;
        status_nxt = ST_OK;
        pay_nxt = 9'((g_r + GW'(HEADER_GRANULES)) << GSH);
        n_nxt = g_r + need_r;
        rd_addr = AW'(sum_w);
      end
      S_A_LINK: begin
        wr_en = 1'b1;
        wr_addr = AW'(n_r);
        wr_start = 1'b1;
        wr_len = len_r - LW'(need_r);
        wr_prev = AW'(g_r);
        fused_nxt = rd_used;
        flen_nxt = rd_len;
      end
      S_A_FIX: begin
        wr_en = 1'b1;
        wr_addr = AW'(sum_w);
        wr_start = 1'b1;
        wr_used = fused_r;
        wr_len = flen_r;
        wr_prev = AW'(n_r);
      end
      S_F_RD: ;
      S_F_NEXT: begin
        len_nxt = rd_len;
        prev_nxt = rd_prev;
        n_nxt = g_r + GW'(rd_len);
        rd_addr = AW'(g_r + GW'(rd_len));
        if (rd_start && rd_used) status_nxt = ST_OK;
      end
      S_F_NLINK: begin
        if (nmerge_w) begin
          len_nxt = len_r + rd_len;
          merged_nxt = 1'b1;
          wr_en = 1'b1;
          wr_addr = AW'(n_r);
          wr_start = 1'b0;
          wr_used = rd_used;
          wr_len = rd_len;
          wr_prev = rd_prev;
        end
        rd_addr = prev_r;
      end
      S_F_PREV: begin
        rd_addr = AW'(sum_w);
        if (pmerge_w) begin
          wr_en = 1'b1;
          wr_addr = AW'(g_r);
          wr_start = 1'b0;
          wr_len = len_r;
          wr_prev = prev_r;
          merged_nxt = 1'b1;
          g_nxt = GW'(prev_r);
          len_nxt = rd_len + len_r;
          prev_nxt = rd_prev;
        end
      end
      S_F_PLINK: begin
        wr_en = 1'b1;
        wr_addr = AW'(g_r);
        wr_start = 1'b1;
        wr_used = 1'b0;
        wr_len = len_r;
        wr_prev = prev_r;
        fused_nxt = rd_used;
        flen_nxt = rd_len;
        n_nxt = sum_w;
      end
      S_F_FIX: begin
        wr_en = 1'b1;
        wr_addr = AW'(n_r);
        wr_start = 1'b1;
        wr_used = fused_r;
        wr_len = flen_r;
        wr_prev = AW'(g_r);
      end
      S_DONE: begin
        if (emit_w) begin
          out_valid_nxt = 1'b1;
          out_status_nxt = status_r;
          out_pay_nxt = pay_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_payload_offset = out_pay_r;

  `FFH_ASSERT(a_ready_idle, clk, rst_n, in_ready |-> state_r == S_IDLE, "ready outside idle")
  `FFH_ASSERT(a_one_result, clk, rst_n, accept_w |=> !in_ready, "second item taken")
  `FFH_ASSERT(a_ok_pay, clk, rst_n, (out_valid && out_status != ST_OK) |-> out_payload_offset == 0, "offset")
  `FFH_ASSERT(a_status, clk, rst_n, out_valid |-> out_status != 2'd3, "bad status code")
  `FFH_ASSERT_NR(a_rst_ready, clk, !rst_n |=> !in_ready, "ready right after reset")
endmodule

// ===== tb/sv/first_fit_heap_allocator_unit_test.sv =====
// Testbench for the first-fit heap allocator: random and directed allocates and frees.
`timescale 1ns / 1ps
module first_fit_heap_allocator_unit_test;
  import ffha_pkg::*;

  localparam int NUM_GRAN = 64;
  localparam int GRAN_BYTES = 8;
  localparam int HDR_GRAN = 2;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic       op;
    logic [9:0] req;
    logic [8:0] off;
  } heap_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [8:0] offset;
  } heap_resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_op = 1'b0;
  logic [9:0] in_request_bytes = '0;
  logic [8:0] in_free_offset = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic [8:0] out_payload_offset;

  first_fit_heap_allocator_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_request_bytes(in_request_bytes), .in_free_offset(in_free_offset),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_payload_offset(out_payload_offset)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  bit         blk_start [NUM_GRAN];
  bit         blk_used [NUM_GRAN];
  int         blk_len [NUM_GRAN];
  int         blk_prev [NUM_GRAN];
  int         live_offsets [$];

  heap_req_t  pending_items [$];
  heap_resp_t expected_resps [$];
  int         mismatches = 0;
  int         cycles = 0;
  bit         quiet = 1'b0;
  bit         hold_send = 1'b0;
  int         in_gap = 0;
  int         out_gap = 0;

  function automatic void heap_reset();
    for (int g = 0; g < NUM_GRAN; g++) begin
      blk_start[g] = 0; blk_used[g] = 0; blk_len[g] = 0; blk_prev[g] = 0;
    end
    blk_start[0] = 1;
    blk_len[0] = NUM_GRAN;
  endfunction

  function automatic void relink(int g);
    int n;
    n = g + blk_len[g];
    if (n < NUM_GRAN && blk_start[n]) blk_prev[n] = g;
  endfunction

  function automatic heap_resp_t heap_predict(heap_req_t it);
    heap_resp_t r;
    int gran, need, g, len, n, p, rem;
    r.status = ST_NOFIT;
    r.offset = '0;
    if (it.op == OP_ALLOC) begin
      gran = (int'(it.req) + GRAN_BYTES - 1) / GRAN_BYTES;
      if (gran == 0) gran = 1;
      need = gran + HDR_GRAN;
      g = 0;
      while (g < NUM_GRAN) begin
        len = blk_len[g];
        if (len == 0) break;
        if (!blk_used[g] && len >= need) begin
          blk_used[g] = 1;
          if (len > need) begin
            rem = g + need;
            blk_len[g] = need;
            blk_start[rem] = 1; blk_used[rem] = 0;
            blk_len[rem] = len - need; blk_prev[rem] = g;
            relink(rem);
          end
          r.status = ST_OK;
          r.offset = 9'((g + HDR_GRAN) * GRAN_BYTES);
          break;
        end
        g += len;
      end
    end else begin
      r.status = ST_BADFREE;
      g = int'(it.off) / GRAN_BYTES - HDR_GRAN;
      if (int'(it.off) % GRAN_BYTES == 0 && g >= 0 && g < NUM_GRAN
          && blk_start[g] && blk_used[g]) begin
        r.status = ST_OK;
        blk_used[g] = 0;
        n = g + blk_len[g];
        if (n < NUM_GRAN && blk_start[n] && !blk_used[n]) begin
          blk_len[g] += blk_len[n];
          blk_start[n] = 0;
          relink(g);
        end
        if (g != 0) begin
          p = blk_prev[g];
          if (blk_start[p] && !blk_used[p]) begin
            blk_len[p] += blk_len[g];
            blk_start[g] = 0;
            relink(p);
          end
        end
      end
    end
    return r;
  endfunction

  function automatic heap_req_t mk_alloc(int bytes);
    heap_req_t it;
    it.op = OP_ALLOC;
    it.req = 10'(bytes);
    it.off = 9'($urandom);
    return it;
  endfunction

  function automatic heap_req_t mk_free(int offset);
    heap_req_t it;
    it.op = OP_FREE;
    it.req = 10'($urandom);
    it.off = 9'(offset);
    return it;
  endfunction

  always @(posedge clk) begin
    heap_req_t it;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        it = pending_items.pop_front();
        expected_resps.push_back(heap_predict(it));
      end
      if (!(in_valid && !in_ready)) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
          in_gap <= $urandom_range(1, 9);
          in_valid <= 1'b0;
        end else if (hold_send && expected_resps.size() > 0) begin
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          it = pending_items[0];
          in_valid <= 1'b1;
          in_op <= it.op;
          in_request_bytes <= it.req;
          in_free_offset <= it.off;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    heap_resp_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_resps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected item status=%0d offset=%0d", out_status, out_payload_offset);
        end else begin
          want = expected_resps.pop_front();
          if (want.status !== out_status || want.offset !== out_payload_offset) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected status=%0d offset=%0d, got status=%0d offset=%0d",
                       want.status, want.offset, out_status, out_payload_offset);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_gap <= $urandom_range(1, 9);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("first_fit_heap_allocator_unit test failed");
      $finish;
    end
  end

  initial begin
    int k, pick, n_items;
    heap_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // Directed part: extremes, exact fit, remainder, bad frees.
    pending_items.push_back(mk_alloc(512));
    pending_items.push_back(mk_alloc(0));
    pending_items.push_back(mk_free(16));
    pending_items.push_back(mk_free(16));
    pending_items.push_back(mk_alloc(496));
    pending_items.push_back(mk_alloc(1));
    pending_items.push_back(mk_free(16));
    pending_items.push_back(mk_alloc(488));
    pending_items.push_back(mk_alloc(0));
    pending_items.push_back(mk_free(17));
    pending_items.push_back(mk_free(8));
    pending_items.push_back(mk_free(0));
    pending_items.push_back(mk_free(511));
    pending_items.push_back(mk_free(504));
    pending_items.push_back(mk_free(24));
    pending_items.push_back(mk_free(16));
    pending_items.push_back(mk_free(24));
    pending_items.push_back(mk_alloc(1023));
    pending_items.push_back(mk_alloc(40));
    pending_items.push_back(mk_alloc(40));
    pending_items.push_back(mk_alloc(40));
    pending_items.push_back(mk_free(72));
    pending_items.push_back(mk_free(16));
    pending_items.push_back(mk_free(128));
    wait (pending_items.size() == 0);
    hold_send = 1'b1;
    wait (expected_resps.size() == 0);
    hold_send = 1'b0;
    // Random part: offsets of live blocks are tracked from a shadow heap.
    n_items = 0;
    while (n_items < 480) begin
      wait (pending_items.size() < 4);
      @(posedge clk);
      if (n_items > 400) quiet = 1'b1;
      live_offsets.delete();
      for (k = 0; k < NUM_GRAN; k++) begin
        // Shadow of the predictor after all queued items is not kept, so
        // frees pick from current live blocks and may become double frees.
        if (blk_start[k] && blk_used[k]) live_offsets.push_back((k + HDR_GRAN) * GRAN_BYTES);
      end
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        if ($urandom_range(0, 7) == 0) pending_items.push_back(mk_alloc($urandom_range(0, 1023)));
        else pending_items.push_back(mk_alloc($urandom_range(0, 120)));
      end else if (pick < 8 && live_offsets.size() > 0) begin
        pending_items.push_back(mk_free(live_offsets[$urandom_range(0, live_offsets.size() - 1)]));
      end else begin
        pending_items.push_back(mk_free($urandom_range(0, 511)));
      end
      n_items++;
    end
    wait (pending_items.size() == 0 && !in_valid);
    wait (expected_resps.size() == 0);
    repeat (300) @(posedge clk);
    if (mismatches == 0 && expected_resps.size() == 0) begin
      $display("first_fit_heap_allocator_unit test passed");
    end else begin
      $display("first_fit_heap_allocator_unit test failed");
    end
    $finish;
  end
endmodule
